FILE: hw/rtl/btr_pkg.sv
// ----------------------------------------------------------------------------
// btr_pkg
// Shared types, constants and the shade palette of the background tile
// renderer.
// ----------------------------------------------------------------------------
package btr_pkg;

	// video memory geometry
	localparam int VRAM_BYTES = 8192;
	localparam int VRAM_AW    = $clog2(VRAM_BYTES);

	// visible tile columns on one screen line
	localparam logic [4:0] SCREEN_COLS = 5'd20;

	// command queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// stream widths
	localparam int S_TDATA_W = 48;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 272;
	localparam int M_TUSER_W = 1;

	// item kinds
	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_TICK   = 2'd1,
		OP_RENDER = 2'd2
	} btr_op_t;

	// result kinds
	localparam logic KIND_TICK   = 1'b0;
	localparam logic KIND_PIXELS = 1'b1;

	// classified command, addr is the write address or the map address
	typedef struct packed {
		btr_op_t              op;
		logic [VRAM_AW-1:0]   addr;
		logic [7:0]           data;
		logic [7:0]           line;
		logic [4:0]           col;
	} btr_cmd_t;

	// four-shade palette, white to black
	function automatic logic [31:0] btr_shade(input logic [1:0] idx);
		logic [31:0] c;
		case (idx)
			2'd0:    c = 32'hFFFFFFFF;
			2'd1:    c = 32'hAAAAAAFF;
			2'd2:    c = 32'h555555FF;
			default: c = 32'h000000FF;
		endcase
		return c;
	endfunction

endpackage

FILE: hw/rtl/btr_front.sv
// ----------------------------------------------------------------------------
// btr_front
// Accepts input transfers, drops items that give nothing and forms the map
// address of render requests.
// ----------------------------------------------------------------------------
module btr_front #(
	parameter int SCREEN_LINES = 144
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      clear_done,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// vram_offset, vram_data, delta, line, tile_column
	input  logic [btr_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// operation
	input  logic [btr_pkg::S_TUSER_W-1:0] s_axis_tuser,
	output logic                      push,
	output btr_pkg::btr_cmd_t         cmd,
	input  logic                      q_full
);
	import btr_pkg::*;

	logic                 valid_s1;
	btr_cmd_t             cmd_s1;
	btr_cmd_t             cmd_new;
	logic                 accept;
	logic                 keep;
	logic [VRAM_AW-1:0]   in_offset;
	logic [7:0]           in_data;
	logic [7:0]           in_delta;
	logic [7:0]           in_line;
	logic [4:0]           in_col;
	logic                 line_ok;
	logic                 col_ok;

	// field unpacking
	assign in_offset = s_axis_tdata[12:0];
	assign in_data   = s_axis_tdata[20:13];
	assign in_delta  = s_axis_tdata[28:21];
	assign in_line   = s_axis_tdata[36:29];
	assign in_col    = s_axis_tdata[41:37];

	assign line_ok = {1'b0, in_line} < 9'(SCREEN_LINES);
	assign col_ok  = in_col < SCREEN_COLS;

	// classify and build the command
	always_comb begin
		keep    = 1'b0;
		cmd_new = '{op: OP_WRITE, addr: in_offset, data: in_data,
			line: in_line, col: in_col};
		unique case (s_axis_tuser)
			OP_WRITE: begin
				keep = 1'b1;
			end
			OP_TICK: begin
				keep         = 1'b1;
				cmd_new.op   = OP_TICK;
				cmd_new.data = in_delta;
			end
			OP_RENDER: begin
				keep         = line_ok && col_ok;
				cmd_new.op   = OP_RENDER;
				// map at 0x1800 + (line / 8) * 32 + column
				cmd_new.addr = {2'b11, 1'b0, in_line[7:3], in_col};
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign push          = valid_s1 && !q_full;
	assign s_axis_tready = clear_done && (!valid_s1 || push);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cmd           = cmd_s1;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= keep;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (accept && keep) begin
			cmd_s1 <= cmd_new;
		end
	end

endmodule

FILE: hw/rtl/btr_queue.sv
// ----------------------------------------------------------------------------
// btr_queue
// Short command queue that lets the front and the back stall on their own.
// ----------------------------------------------------------------------------
module btr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  btr_pkg::btr_cmd_t push_cmd,
	output logic              full,
	output logic              head_valid,
	output btr_pkg::btr_cmd_t head,
	input  logic              pop
);
	import btr_pkg::*;

	btr_cmd_t            slots_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	assign full       = count_q == (QPTR_W + 1)'(QDEPTH);
	assign head_valid = count_q != '0;
	assign head       = slots_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

FILE: hw/rtl/btr_back.sv
// ----------------------------------------------------------------------------
// btr_back
// Owns video memory and the frame counter, runs writes, ticks and the three
// dependent reads of a render, and holds the result register.
// ----------------------------------------------------------------------------
module btr_back #(
	parameter int FRAME_CYCLES = 70224
) (
	input  logic                      clk,
	input  logic                      arst_n,
	output logic                      clear_done,
	input  logic                      head_valid,
	input  btr_pkg::btr_cmd_t         head,
	output logic                      pop,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// frame_due, out_line, out_column, pixel_0 .. pixel_7, zero fill
	output logic [btr_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// result_kind
	output logic [btr_pkg::M_TUSER_W-1:0] m_axis_tuser
);
	import btr_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TILE,
		ST_LO,
		ST_HI
	} state_t;

	state_t               state_q;
	logic [VRAM_AW-1:0]   clr_addr_q;
	logic [16:0]          count_q;
	logic [7:0]           line_q;
	logic [4:0]           col_q;
	logic [7:0]           tile_q;
	logic [7:0]           lo_q;

	// memory port
	logic [7:0]           vram_mem [VRAM_BYTES];
	logic [7:0]           rd_q;
	logic                 mem_we;
	logic                 mem_re;
	logic [VRAM_AW-1:0]   mem_addr;
	logic [7:0]           mem_wd;

	// result register
	logic                 out_valid_q;
	logic                 out_kind_q;
	logic                 out_due_q;
	logic [7:0]           out_line_q;
	logic [4:0]           out_col_q;
	logic [7:0]           out_lo_q;
	logic [7:0]           out_hi_q;
	logic                 out_free;
	logic                 out_load;
	logic [255:0]         pix;

	// tick arithmetic
	logic [17:0]          tick_sum;
	logic                 tick_due;
	logic [16:0]          tick_next;

	assign out_free   = !out_valid_q || m_axis_tready;
	assign clear_done = state_q != ST_CLEAR;

	// result register loads a tick status or a finished tile row
	assign out_load = ((state_q == ST_IDLE) && head_valid && (head.op == OP_TICK) && out_free)
		|| ((state_q == ST_HI) && out_free);

	assign tick_sum  = {1'b0, count_q} + 18'(head.data);
	assign tick_due  = tick_sum >= 18'(FRAME_CYCLES);
	assign tick_next = tick_due ? 17'(tick_sum - 18'(FRAME_CYCLES)) : tick_sum[16:0];

	// memory access and queue pop per state
	always_comb begin
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_addr = head.addr;
		mem_wd   = head.data;
		pop      = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_addr_q;
				mem_wd   = '0;
			end
			ST_IDLE: begin
				if (head_valid) begin
					unique case (head.op)
						OP_WRITE: begin
							mem_we = 1'b1;
							pop    = 1'b1;
						end
						OP_TICK: begin
							pop = out_free;
						end
						OP_RENDER: begin
							mem_re = 1'b1;
							pop    = 1'b1;
						end
						default: begin
							pop = 1'b1;
						end
					endcase
				end
			end
			ST_TILE: begin
				// tile * 16 + (line % 8) * 2
				mem_re   = 1'b1;
				mem_addr = {1'b0, rd_q, line_q[2:0], 1'b0};
			end
			ST_LO: begin
				mem_re   = 1'b1;
				mem_addr = {1'b0, tile_q, line_q[2:0], 1'b1};
			end
			ST_HI: begin
			end
			default: begin
			end
		endcase
	end

	// single port video memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			vram_mem[mem_addr] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= vram_mem[mem_addr];
		end
	end

	// sequencer, frame counter and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_TICK;
			out_due_q   <= 1'b0;
			out_line_q  <= '0;
			out_col_q   <= '0;
			out_lo_q    <= '0;
			out_hi_q    <= '0;
			line_q      <= '0;
			col_q       <= '0;
			tile_q      <= '0;
			lo_q        <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == VRAM_AW'(VRAM_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (head_valid && head.op == OP_TICK && out_free) begin
						count_q    <= tick_next;
						out_kind_q <= KIND_TICK;
						out_due_q  <= tick_due;
						out_line_q <= '0;
						out_col_q  <= '0;
					end
					if (head_valid && head.op == OP_RENDER) begin
						line_q  <= head.line;
						col_q   <= head.col;
						state_q <= ST_TILE;
					end
				end
				ST_TILE: begin
					tile_q  <= rd_q;
					state_q <= ST_LO;
				end
				ST_LO: begin
					lo_q    <= rd_q;
					state_q <= ST_HI;
				end
				ST_HI: begin
					if (out_free) begin
						out_kind_q <= KIND_PIXELS;
						out_due_q  <= 1'b0;
						out_line_q <= line_q;
						out_col_q  <= col_q;
						out_lo_q   <= lo_q;
						out_hi_q   <= rd_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// palette lookup, leftmost pixel from bit 7 of both planes
	always_comb begin
		pix = '0;
		if (out_kind_q == KIND_PIXELS) begin
			for (int j = 0; j < 8; j++) begin
				pix[j*32 +: 32] = btr_shade({out_hi_q[7-j], out_lo_q[7-j]});
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tdata  = {2'b00, pix, out_col_q, out_line_q, out_due_q};

endmodule

FILE: hw/rtl/background_tile_renderer.sv
// ----------------------------------------------------------------------------
// background_tile_renderer
// Tile row renderer with 8 KiB video memory and a frame cycle counter.
// ----------------------------------------------------------------------------
// Items arrive on the s_axis channel, operation in tuser. A write stores one
// byte and gives no transfer out. A tick adds delta to the frame counter and
// gives one m_axis transfer (tuser 0) with frame_due set when the counter
// reached FRAME_CYCLES. A render request inside the screen gives one transfer
// (tuser 1) with eight RGBA pixels; requests off screen and unused operation
// codes are dropped. Results leave in input order.
// In the back end a write or a tick is handled in the idle state, and a render
// steps through the map read and the two tile plane reads that follow one
// another on the single video memory port; no new command is taken until the
// render result is loaded. Each item passes the input stage and the queue first.
// A four-entry command queue sits between the input stage and the back end,
// so the input keeps taking items while a result waits on m_axis_tready.
// After reset a pass zeroes all 8192 bytes of video memory; s_axis_tready
// stays low until it is done. A stalled receiver holds the result register
// and, once the queue fills, backs up to s_axis_tready.
// ----------------------------------------------------------------------------
module background_tile_renderer #(
	parameter int FRAME_CYCLES = 70224,
	parameter int SCREEN_LINES = 144
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// vram_offset, vram_data, delta, line, tile_column, zero fill
	input  logic [btr_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// operation
	input  logic [btr_pkg::S_TUSER_W-1:0] s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// frame_due, out_line, out_column, pixel_0 .. pixel_7, zero fill
	output logic [btr_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// result_kind
	output logic [btr_pkg::M_TUSER_W-1:0] m_axis_tuser
);
	import btr_pkg::*;

	logic     clear_done;
	logic     push;
	btr_cmd_t push_cmd;
	logic     q_full;
	logic     head_valid;
	btr_cmd_t head;
	logic     pop;

	// input stage and classification
	btr_front #(
		.SCREEN_LINES(SCREEN_LINES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.clear_done   (clear_done),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.push         (push),
		.cmd          (push_cmd),
		.q_full       (q_full)
	);

	// command queue
	btr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop)
	);

	// execution and result register
	btr_back #(
		.FRAME_CYCLES(FRAME_CYCLES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.clear_done   (clear_done),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

endmodule
